// ===== src/b64e_pkg.sv =====
package b64e_pkg;

    localparam int COUNT_BITS = 16;
    localparam int CAP_W      = 16;
    localparam int CMP_W      = ((COUNT_BITS > CAP_W) ? COUNT_BITS : CAP_W) + 1;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);

    localparam logic [7:0] PAD_CHAR    = 8'h3D;
    localparam logic [7:0] MARKER_CHAR = 8'h00;

    typedef logic [COUNT_BITS-1:0] cnt_t;
    typedef logic [CMP_W-1:0]      cmp_t;
    typedef logic [PTR_W-1:0]      ptr_t;
    typedef logic [PTR_W:0]        fill_t;

    // One finished group, or the truncation marker of a message.
    typedef struct packed {
        logic [23:0] triple;
        logic [1:0]  nbytes;
        logic        last;
        logic        marker;
    } grp_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] c;
        begin
            if (v < 6'd26)
                c = 8'h41 + 8'(v);
            else if (v < 6'd52)
                c = 8'h61 + 8'(v - 6'd26);
            else if (v < 6'd62)
                c = 8'h30 + 8'(v - 6'd52);
            else if (v == 6'd62)
                c = 8'h2B;
            else
                c = 8'h2F;
            return c;
        end
    endfunction

endpackage

// ===== src/b64e_front.sv =====
module b64e_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,
    input  logic                         s_tlast,
    input  logic [b64e_pkg::CAP_W-1:0]   out_capacity,
    input  b64e_pkg::fifo_stat_t         fifo_stat,
    output logic                         push,
    output b64e_pkg::grp_t               push_grp
);

    logic [7:0]      held_hi_reg, held_hi_next;
    logic [7:0]      held_lo_reg, held_lo_next;
    logic [1:0]      held_count_reg, held_count_next;
    b64e_pkg::cnt_t  chars_reg, chars_next;
    logic            ovf_reg, ovf_next;

    logic            accept;
    logic [1:0]      nbytes;
    logic            complete;
    logic [23:0]     triple;
    b64e_pkg::cmp_t  next_cnt;
    logic            fits;
    logic            emit;
    logic            ovf_new;
    logic            marker;

    assign s_tready = !fifo_stat.full;
    assign accept   = s_tvalid && s_tready;
    assign nbytes   = held_count_reg + 2'd1;
    assign complete = (nbytes == 2'd3) || s_tlast;

    always_comb
    begin
        unique case (held_count_reg)
            2'd0:    triple = {s_tdata, 16'h0000};
            2'd1:    triple = {held_hi_reg, s_tdata, 8'h00};
            default: triple = {held_hi_reg, held_lo_reg, s_tdata};
        endcase
    end

    // Group fits only if both the capacity and the counter range allow it.
    assign next_cnt = b64e_pkg::cmp_t'(chars_reg) + b64e_pkg::cmp_t'(4);
    assign fits     = (next_cnt <= b64e_pkg::cmp_t'(out_capacity))
                   && (next_cnt <= b64e_pkg::cmp_t'({b64e_pkg::COUNT_BITS{1'b1}}));
    assign emit     = complete && !ovf_reg && fits;
    assign ovf_new  = ovf_reg || (complete && !fits);
    assign marker   = s_tlast && ovf_new;

    assign push            = accept && complete && (emit || marker);
    assign push_grp.triple = triple;
    assign push_grp.nbytes = nbytes;
    assign push_grp.last   = s_tlast;
    assign push_grp.marker = marker;

    always_comb
    begin
        held_hi_next    = held_hi_reg;
        held_lo_next    = held_lo_reg;
        held_count_next = held_count_reg;
        chars_next      = chars_reg;
        ovf_next        = ovf_reg;
        if (accept)
        begin
            if (!complete)
            begin
                held_count_next = nbytes;
                if (held_count_reg == 2'd0)
                    held_hi_next = s_tdata;
                else
                    held_lo_next = s_tdata;
            end
            else if (s_tlast)
            begin
                held_count_next = 2'd0;
                chars_next      = '0;
                ovf_next        = 1'b0;
            end
            else
            begin
                held_count_next = 2'd0;
                ovf_next        = ovf_new;
                if (emit)
                    chars_next = next_cnt[b64e_pkg::COUNT_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_hi_reg    <= '0;
            held_lo_reg    <= '0;
            held_count_reg <= '0;
            chars_reg      <= '0;
            ovf_reg        <= 1'b0;
        end
        else
        begin
            held_hi_reg    <= held_hi_next;
            held_lo_reg    <= held_lo_next;
            held_count_reg <= held_count_next;
            chars_reg      <= chars_next;
            ovf_reg        <= ovf_next;
        end
    end

endmodule

// ===== src/b64e_fifo.sv =====
module b64e_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  b64e_pkg::grp_t        push_grp,
    input  logic                  pop,
    output b64e_pkg::grp_t        head,
    output b64e_pkg::fifo_stat_t  fifo_stat
);

    b64e_pkg::grp_t  slot_reg [b64e_pkg::FIFO_DEPTH];
    b64e_pkg::ptr_t  wr_ptr_reg, wr_ptr_next;
    b64e_pkg::ptr_t  rd_ptr_reg, rd_ptr_next;
    b64e_pkg::fill_t fill_reg, fill_next;

    assign head            = slot_reg[rd_ptr_reg];
    assign fifo_stat.full  = (fill_reg == b64e_pkg::fill_t'(b64e_pkg::FIFO_DEPTH));
    assign fifo_stat.empty = (fill_reg == '0);

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + b64e_pkg::ptr_t'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + b64e_pkg::ptr_t'(1) : rd_ptr_reg;
        fill_next   = fill_reg + b64e_pkg::fill_t'(push) - b64e_pkg::fill_t'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_grp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

// ===== src/b64e_back.sv =====
module b64e_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  b64e_pkg::grp_t        head,
    input  b64e_pkg::fifo_stat_t  fifo_stat,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,
    output logic                  m_tlast,
    output logic [1:0]            m_tuser
);

    logic [1:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] sym_reg, sym_next;
    logic       gend_reg, gend_next;
    logic       mend_reg, mend_next;
    logic       trunc_reg, trunc_next;

    logic       load;
    logic [7:0] chr;

    assign load = !fifo_stat.empty && (!out_valid_reg || m_tready);

    always_comb
    begin
        unique case (idx_reg)
            2'd0:    chr = b64e_pkg::b64_char(head.triple[23:18]);
            2'd1:    chr = b64e_pkg::b64_char(head.triple[17:12]);
            2'd2:    chr = (head.nbytes < 2'd2) ? b64e_pkg::PAD_CHAR
                                                : b64e_pkg::b64_char(head.triple[11:6]);
            default: chr = (head.nbytes < 2'd3) ? b64e_pkg::PAD_CHAR
                                                : b64e_pkg::b64_char(head.triple[5:0]);
        endcase
    end

    always_comb
    begin
        idx_next       = idx_reg;
        sym_next       = sym_reg;
        gend_next      = gend_reg;
        mend_next      = mend_reg;
        trunc_next     = trunc_reg;
        pop            = 1'b0;
        out_valid_next = out_valid_reg && !m_tready;
        if (load)
        begin
            out_valid_next = 1'b1;
            if (head.marker)
            begin
                sym_next   = b64e_pkg::MARKER_CHAR;
                gend_next  = 1'b0;
                mend_next  = 1'b1;
                trunc_next = 1'b1;
                pop        = 1'b1;
            end
            else
            begin
                sym_next   = chr;
                gend_next  = (idx_reg == 2'd3);
                mend_next  = (idx_reg == 2'd3) && head.last;
                trunc_next = 1'b0;
                idx_next   = idx_reg + 2'd1;
                pop        = (idx_reg == 2'd3);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg   <= sym_next;
        gend_reg  <= gend_next;
        mend_reg  <= mend_next;
        trunc_reg <= trunc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = sym_reg;
    assign m_tlast  = mend_reg;
    assign m_tuser  = {trunc_reg, gend_reg};

endmodule

// ===== src/base64_encoder.sv =====
// Base64 encoder (standard alphabet, '=' padding). Message bytes enter one per
// beat on the slave side, tlast on the final byte, and the block takes a byte
// in every cycle while its four-entry group queue has room. Each group of three
// bytes (or a short final group) leaves as four characters, one per cycle from
// the output register while the receiver is ready, so the character side sets
// the sustained rate. A group is emitted only if its four characters stay
// within out_capacity for the message; a group that does not fit is dropped
// along with every later group of that message, and the message then ends
// with a single marker beat (symbol 0, truncated set, tlast set) instead of
// characters. Write out_capacity only while the block is idle.
module base64_encoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // symbol
    output logic        m_tlast,   // message_end
    output logic [1:0]  m_tuser,   // [0] group_end, [1] truncated
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data   // out_capacity
);

    logic [b64e_pkg::CAP_W-1:0] cap_reg, cap_next;

    logic                 push;
    logic                 pop;
    b64e_pkg::grp_t       push_grp;
    b64e_pkg::grp_t       head;
    b64e_pkg::fifo_stat_t fifo_stat;

    assign cfg_ready = 1'b1;
    assign cap_next  = (cfg_valid && cfg_ready) ? cfg_data : cap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= '1;
        else
            cap_reg <= cap_next;
    end

    b64e_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .out_capacity (cap_reg),
        .fifo_stat    (fifo_stat),
        .push         (push),
        .push_grp     (push_grp)
    );

    b64e_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_grp  (push_grp),
        .pop       (pop),
        .head      (head),
        .fifo_stat (fifo_stat)
    );

    b64e_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .fifo_stat (fifo_stat),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

// ===== tb/base64_encoder_test.sv =====
module base64_encoder_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES = 32;
    localparam logic [511:0] B64_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef enum logic [1:0] {ROW_CAP, ROW_BYTE, ROW_CHARS, ROW_MARKER} row_kind_t;

    // ROW_CAP writes value as capacity; ROW_CHARS expects the four characters in text
    typedef struct packed {
        row_kind_t   kind;
        logic [15:0] value;
        logic        last;
        logic [31:0] text;
    } stim_row_t;

    typedef struct packed {
        logic [7:0] symbol;
        logic       group_end;
        logic       message_end;
        logic       truncated;
    } sym_beat_t;

    localparam stim_row_t DIRECTED [30] = '{
        '{ROW_CHARS,  16'h0000, 1'b1, "AA=="},
        '{ROW_CHARS,  16'h00FF, 1'b1, "/w=="},
        '{ROW_BYTE,   16'h00FF, 1'b0, 32'h0},
        '{ROW_BYTE,   16'h00FF, 1'b0, 32'h0},
        '{ROW_CHARS,  16'h00FF, 1'b1, "////"},
        '{ROW_BYTE,   16'h004D, 1'b0, 32'h0},
        '{ROW_BYTE,   16'h0061, 1'b0, 32'h0},
        '{ROW_CHARS,  16'h006E, 1'b0, "TWFu"},
        '{ROW_BYTE,   16'h004D, 1'b0, 32'h0},
        '{ROW_CHARS,  16'h0061, 1'b1, "TWE="},
        // no room at all: the lone group is dropped
        '{ROW_CAP,    16'd0,    1'b0, 32'h0},
        '{ROW_MARKER, 16'h0041, 1'b1, 32'h0},
        // capacity raised mid-message applies to the next group
        '{ROW_CAP,    16'd4,    1'b0, 32'h0},
        '{ROW_BYTE,   16'h0012, 1'b0, 32'h0},
        '{ROW_BYTE,   16'h0034, 1'b0, 32'h0},
        '{ROW_BYTE,   16'h0056, 1'b0, 32'h0},
        '{ROW_BYTE,   16'h0078, 1'b0, 32'h0},
        '{ROW_CAP,    16'd8,    1'b0, 32'h0},
        '{ROW_BYTE,   16'h009A, 1'b0, 32'h0},
        '{ROW_BYTE,   16'h00BC, 1'b0, 32'h0},
        '{ROW_MARKER, 16'h00DE, 1'b1, 32'h0},
        // once a group is dropped, later groups stay dropped despite room
        '{ROW_CAP,    16'd4,    1'b0, 32'h0},
        '{ROW_BYTE,   16'h0001, 1'b0, 32'h0},
        '{ROW_BYTE,   16'h0002, 1'b0, 32'h0},
        '{ROW_BYTE,   16'h0003, 1'b0, 32'h0},
        '{ROW_BYTE,   16'h0004, 1'b0, 32'h0},
        '{ROW_BYTE,   16'h0005, 1'b0, 32'h0},
        '{ROW_BYTE,   16'h0006, 1'b0, 32'h0},
        '{ROW_CAP,    16'hFFFF, 1'b0, 32'h0},
        '{ROW_MARKER, 16'h0007, 1'b1, 32'h0}
    };

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic [1:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    // encoder state as the block should hold it
    logic [15:0]     cap_limit;
    logic [15:0]     held_pair;
    logic [1:0]      held_n;
    b64e_pkg::cnt_t  chars_sent;
    logic            dropped;

    sym_beat_t   expected_syms[$];
    int          errors;
    bit          idle_on;
    int          stall_left = 0;

    base64_encoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("base64_encoder verification failed");
        $finish;
    end

    function automatic logic [7:0] b64_symbol(input logic [5:0] v);
        return B64_ALPHABET[8 * (63 - int'(v)) +: 8];
    endfunction

    function automatic void encode_byte(input logic [7:0] b, input logic last,
                                        output sym_beat_t beats [4], output int n);
        logic [1:0]                    nbytes;
        logic [23:0]                   triple;
        logic [b64e_pkg::COUNT_BITS:0] next;
        n = 0;
        beats = '{default: '0};
        if (held_n == 2'd0)
            held_pair = {b, 8'h00};
        else if (held_n == 2'd1)
            held_pair[7:0] = b;
        nbytes = held_n + 2'd1;
        if (nbytes < 2'd3 && !last)
        begin
            held_n = nbytes;
            return;
        end
        triple = (nbytes == 2'd3) ? {held_pair, b} : {held_pair, 8'h00};
        held_n = 2'd0;
        held_pair = 16'h0000;
        if (!dropped)
        begin
            next = {1'b0, chars_sent} + (b64e_pkg::COUNT_BITS + 1)'(4);
            if (next <= {1'b0, cap_limit}
                && next <= {1'b0, {b64e_pkg::COUNT_BITS{1'b1}}})
            begin
                beats[0].symbol = b64_symbol(triple[23:18]);
                beats[1].symbol = b64_symbol(triple[17:12]);
                beats[2].symbol = (nbytes < 2'd2) ? b64e_pkg::PAD_CHAR
                                                  : b64_symbol(triple[11:6]);
                beats[3].symbol = (nbytes < 2'd3) ? b64e_pkg::PAD_CHAR
                                                  : b64_symbol(triple[5:0]);
                beats[3].group_end = 1'b1;
                beats[3].message_end = last;
                n = 4;
                chars_sent = next[b64e_pkg::COUNT_BITS-1:0];
            end
            else
                dropped = 1'b1;
        end
        if (last)
        begin
            if (dropped)
            begin
                beats[0] = '{symbol: b64e_pkg::MARKER_CHAR, group_end: 1'b0,
                             message_end: 1'b1, truncated: 1'b1};
                n = 1;
            end
            chars_sent = '0;
            dropped = 1'b0;
        end
    endfunction

    // hold the byte until accepted, then queue what it should produce
    task automatic send_byte(input logic [7:0] b, input logic last,
                             input row_kind_t kind, input logic [31:0] text);
        sym_beat_t beats [4];
        int        n;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        encode_byte(b, last, beats, n);
        if (kind == ROW_CHARS)
        begin
            for (int i = 0; i < 4; i++)
                expected_syms.push_back('{symbol: text[8 * (3 - i) +: 8],
                                          group_end: (i == 3),
                                          message_end: (i == 3) && last,
                                          truncated: 1'b0});
        end
        else if (kind == ROW_MARKER)
            expected_syms.push_back('{symbol: b64e_pkg::MARKER_CHAR, group_end: 1'b0,
                                      message_end: 1'b1, truncated: 1'b1});
        else
        begin
            for (int i = 0; i < n; i++)
                expected_syms.push_back(beats[i]);
        end
    endtask

    // drop valid, wait for every pending character, then let a dropped group settle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_syms.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [15:0] cap);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cap_limit = cap;
    endtask

    task automatic send_message(input int len);
        for (int i = 0; i < len; i++)
            send_byte(8'($urandom_range(0, 255)), i == len - 1, ROW_BYTE, 32'h0);
    endtask

    function automatic void check_field(input string field, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin : check_beats
        sym_beat_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_syms.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none, actual symbol %0h last %b user %b",
                         $time, m_tdata, m_tlast, m_tuser);
                errors++;
            end
            else
            begin
                want = expected_syms.pop_front();
                check_field("symbol", want.symbol, m_tdata);
                check_field("group_end", 8'(want.group_end), 8'(m_tuser[0]));
                check_field("message_end", 8'(want.message_end), 8'(m_tlast));
                check_field("truncated", 8'(want.truncated), 8'(m_tuser[1]));
            end
        end
    end

    // receiver drops ready in random bursts while idle_on is set
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 15);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    initial
    begin
        logic [15:0] phase_caps [7];
        int          sent;
        int          len;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = 8'h00;
        s_tlast    = 1'b0;
        cfg_valid  = 1'b0;
        cfg_data   = 16'h0000;
        errors     = 0;
        idle_on    = 1'b1;
        cap_limit  = 16'hFFFF;
        held_pair  = 16'h0000;
        held_n     = 2'd0;
        chars_sent = '0;
        dropped    = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
        begin
            if (DIRECTED[i].kind == ROW_CAP)
                write_capacity(DIRECTED[i].value);
            else
                send_byte(DIRECTED[i].value[7:0], DIRECTED[i].last,
                          DIRECTED[i].kind, DIRECTED[i].text);
        end

        phase_caps = '{16'hFFFF, 16'd0, 16'd4, 16'd8, 16'd13,
                       16'($urandom_range(0, 65535)), 16'hFFFF};
        foreach (phase_caps[p])
        begin
            write_capacity(phase_caps[p]);
            // run the last phase at full rate on both sides
            if (p == 6)
                idle_on = 1'b0;
            sent = 0;
            while (sent < 16)
            begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 24)
                                                  : $urandom_range(1, 9);
                send_message(len);
                sent += len;
            end
        end

        wait_drained();
        if (errors == 0)
            $display("base64_encoder verification clean");
        else
            $display("base64_encoder verification failed");
        $finish;
    end

endmodule

// ===== base64_encoder.f =====
src/b64e_pkg.sv
src/b64e_front.sv
src/b64e_fifo.sv
src/b64e_back.sv
src/base64_encoder.sv
tb/base64_encoder_test.sv
